FILE: rtl/core/ppm_stream_decoder_unit_assert.svh
// ----------------------------------------------------------------------------
// PPM stream decoder assertion macros
// Concurrent assertion wrappers, clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef PPM_STREAM_DECODER_UNIT_ASSERT_SVH
`define PPM_STREAM_DECODER_UNIT_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define PPM_SDU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must be followed by a consequence at the next edge.
`define PPM_SDU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/ppm_sdu_pkg.sv
// ----------------------------------------------------------------------------
// PPM stream decoder package
// Shared constants, status codes and the result type of the decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ppm_sdu_pkg;

  localparam int MAX_DIM         = 16384;
  localparam int TOKEN_LEN_LIMIT = 32;

  // Storage widths that follow from the limits above.
  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int PIX_W = 2 * DIM_W;
  localparam int LEN_W = $clog2(TOKEN_LEN_LIMIT);

  // Width of the dimension fields on the result.
  localparam int IMG_DIM_W = 15;

  localparam logic [7:0]  CH_P       = 8'h50;
  localparam logic [7:0]  CH_3       = 8'h33;
  localparam logic [7:0]  CH_6       = 8'h36;
  localparam logic [7:0]  CH_HASH    = 8'h23;
  localparam logic [7:0]  CH_ZERO    = 8'h30;
  localparam logic [7:0]  CH_NINE    = 8'h39;
  localparam logic [7:0]  CH_SPACE   = 8'h20;
  localparam logic [7:0]  CH_TAB     = 8'h09;
  localparam logic [7:0]  CH_LF      = 8'h0a;
  localparam logic [7:0]  CH_VT      = 8'h0b;
  localparam logic [7:0]  CH_FF      = 8'h0c;
  localparam logic [7:0]  CH_CR      = 8'h0d;
  localparam logic [31:0] SAMPLE_MAX  = 32'd255;
  localparam logic [31:0] PIXEL_ALPHA = 32'hff000000;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_MALFORMED   = 2'd1,
    ST_UNSUPPORTED = 2'd2,
    ST_DIM_LIMIT   = 2'd3
  } status_t;

  typedef struct packed {
    logic [31:0]          pixel_value;
    status_t              status;
    logic                 image_done;
    logic [IMG_DIM_W-1:0] image_width;
    logic [IMG_DIM_W-1:0] image_height;
  } res_t;

endpackage

FILE: rtl/core/ppm_sdu_parser.sv
// ----------------------------------------------------------------------------
// PPM stream decoder parser
// Header tokeniser, sample assembly and pixel counting, one byte per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ppm_stream_decoder_unit_assert.svh"

module ppm_sdu_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [7:0]         data_byte,
  input  logic               end_of_source,
  output logic               res_valid,
  output ppm_sdu_pkg::res_t  res
);

  typedef enum logic [5:0] {
    PH_MAGIC  = 6'b000001,
    PH_WIDTH  = 6'b000010,
    PH_HEIGHT = 6'b000100,
    PH_MAXVAL = 6'b001000,
    PH_BIN    = 6'b010000,
    PH_ASC    = 6'b100000
  } phase_t;

  typedef enum logic [1:0] {
    TERM_SPACE = 2'd0,
    TERM_HASH  = 2'd1,
    TERM_END   = 2'd2
  } term_t;

  localparam logic [ppm_sdu_pkg::LEN_W-1:0] LEN_LAST =
    ppm_sdu_pkg::LEN_W'(ppm_sdu_pkg::TOKEN_LEN_LIMIT - 1);

  phase_t                          phase, phase_next;
  logic                            ascii_mode, ascii_mode_next;
  logic [31:0]                     number_accum, number_accum_next;
  logic [ppm_sdu_pkg::LEN_W-1:0]   token_length, token_length_next;
  logic                            in_comment, in_comment_next;
  logic                            token_bad, token_bad_next;
  logic                            dim_over, dim_over_next;
  logic [ppm_sdu_pkg::DIM_W-1:0]   width_store, width_store_next;
  logic [ppm_sdu_pkg::DIM_W-1:0]   height_store, height_store_next;
  logic [1:0]                      channel_index, channel_index_next;
  logic [7:0]                      red_hold, red_hold_next;
  logic [7:0]                      green_hold, green_hold_next;
  logic [ppm_sdu_pkg::PIX_W-1:0]   pixels_left, pixels_left_next;
  logic                            finished, finished_next;

  logic                            byte_space;
  logic                            byte_hash;
  logic                            byte_digit;
  logic [35:0]                     accum_sum;
  logic                            accum_ovf;
  logic                            tok_char;
  logic                            do_finish;
  term_t                           fin_term;
  logic [31:0]                     fin_value;
  logic                            fin_bad;
  logic                            take;
  logic [7:0]                      sample;
  logic [ppm_sdu_pkg::PIX_W-1:0]   left_dec;

  function automatic ppm_sdu_pkg::res_t fail_res(input ppm_sdu_pkg::status_t st);
    ppm_sdu_pkg::res_t r;
    r            = '0;
    r.status     = st;
    r.image_done = 1'b1;
    return r;
  endfunction

  assign byte_space = (data_byte == ppm_sdu_pkg::CH_SPACE) || (data_byte == ppm_sdu_pkg::CH_TAB) ||
                      (data_byte == ppm_sdu_pkg::CH_CR) || (data_byte == ppm_sdu_pkg::CH_LF) ||
                      (data_byte == ppm_sdu_pkg::CH_FF) || (data_byte == ppm_sdu_pkg::CH_VT);
  assign byte_hash  = (data_byte == ppm_sdu_pkg::CH_HASH);
  assign byte_digit = (data_byte >= ppm_sdu_pkg::CH_ZERO) && (data_byte <= ppm_sdu_pkg::CH_NINE);

  // Ten times the accumulator plus the digit, wide enough to see a 32-bit overflow.
  assign accum_sum = {1'b0, number_accum, 3'b000} + {3'b000, number_accum, 1'b0} +
                     36'(data_byte - ppm_sdu_pkg::CH_ZERO);
  assign accum_ovf = |accum_sum[35:32];

  always_comb begin
    phase_next         = phase;
    ascii_mode_next    = ascii_mode;
    number_accum_next  = number_accum;
    token_length_next  = token_length;
    in_comment_next    = in_comment;
    token_bad_next     = token_bad;
    dim_over_next      = dim_over;
    width_store_next   = width_store;
    height_store_next  = height_store;
    channel_index_next = channel_index;
    red_hold_next      = red_hold;
    green_hold_next    = green_hold;
    pixels_left_next   = pixels_left;
    finished_next      = finished;
    res_valid          = 1'b0;
    res                = '0;
    tok_char           = 1'b0;
    do_finish          = 1'b0;
    fin_term           = TERM_END;
    fin_value          = '0;
    fin_bad            = 1'b0;
    take               = 1'b0;
    sample             = data_byte;
    left_dec           = '0;

    if (!finished) begin
      unique case (phase)
        PH_MAGIC: begin
          if (token_length == '0) begin
            if (data_byte != ppm_sdu_pkg::CH_P) begin
              res_valid = 1'b1; res = fail_res(ppm_sdu_pkg::ST_UNSUPPORTED); finished_next = 1'b1;
            end else begin
              token_length_next = ppm_sdu_pkg::LEN_W'(1);
            end
          end else if (token_length == ppm_sdu_pkg::LEN_W'(1)) begin
            if ((data_byte != ppm_sdu_pkg::CH_3) && (data_byte != ppm_sdu_pkg::CH_6)) begin
              res_valid = 1'b1; res = fail_res(ppm_sdu_pkg::ST_UNSUPPORTED); finished_next = 1'b1;
            end else begin
              ascii_mode_next   = (data_byte == ppm_sdu_pkg::CH_3);
              token_length_next = ppm_sdu_pkg::LEN_W'(2);
            end
          end else if (byte_space || byte_hash) begin
            if (token_length != ppm_sdu_pkg::LEN_W'(2)) begin
              res_valid = 1'b1; res = fail_res(ppm_sdu_pkg::ST_UNSUPPORTED); finished_next = 1'b1;
            end else begin
              token_length_next = '0;
              number_accum_next = '0;
              in_comment_next   = byte_hash;
              phase_next        = PH_WIDTH;
            end
          end else if (token_length >= LEN_LAST) begin
            res_valid = 1'b1; res = fail_res(ppm_sdu_pkg::ST_MALFORMED); finished_next = 1'b1;
          end else begin
            token_length_next = token_length + 1'b1;
          end
        end
        PH_BIN: begin
          take = 1'b1;
        end
        default: begin
          if (in_comment) begin
            if (data_byte == ppm_sdu_pkg::CH_LF) begin
              in_comment_next = 1'b0;
            end
          end else if (token_length == '0) begin
            if (byte_hash) begin
              in_comment_next = 1'b1;
            end else if (!byte_space) begin
              tok_char = 1'b1;
            end
          end else if (byte_space) begin
            do_finish = 1'b1;
            fin_term  = TERM_SPACE;
          end else if (byte_hash) begin
            do_finish = 1'b1;
            fin_term  = TERM_HASH;
          end else begin
            tok_char = 1'b1;
          end
        end
      endcase

      // A token that fills the capacity is closed at once as a bad token.
      if (tok_char) begin
        if (token_length >= LEN_LAST) begin
          token_bad_next = 1'b1;
          do_finish      = 1'b1;
          fin_term       = TERM_END;
        end else begin
          token_length_next = token_length + 1'b1;
          if (!byte_digit || accum_ovf) begin
            token_bad_next = 1'b1;
          end else begin
            number_accum_next = accum_sum[31:0];
          end
        end
      end
    end

    // The last byte of the source closes a token still open in the header or samples.
    if (end_of_source && !finished_next && !do_finish && (token_length_next != '0) &&
        (phase != PH_MAGIC) && (phase != PH_BIN)) begin
      do_finish = 1'b1;
      fin_term  = TERM_END;
    end

    if (do_finish) begin
      fin_value         = number_accum_next;
      fin_bad           = token_bad_next;
      token_length_next = '0;
      number_accum_next = '0;
      token_bad_next    = 1'b0;
      if (fin_term == TERM_HASH) begin
        in_comment_next = 1'b1;
      end
      if (phase == PH_ASC) begin
        if (fin_bad || (fin_value > ppm_sdu_pkg::SAMPLE_MAX)) begin
          res_valid = 1'b1; res = fail_res(ppm_sdu_pkg::ST_MALFORMED); finished_next = 1'b1;
        end else begin
          take   = 1'b1;
          sample = fin_value[7:0];
        end
      end else if (fin_bad) begin
        res_valid = 1'b1; res = fail_res(ppm_sdu_pkg::ST_UNSUPPORTED); finished_next = 1'b1;
      end else if ((phase == PH_WIDTH) || (phase == PH_HEIGHT)) begin
        if (fin_value == '0) begin
          res_valid = 1'b1; res = fail_res(ppm_sdu_pkg::ST_UNSUPPORTED); finished_next = 1'b1;
        end else begin
          if (fin_value > 32'(ppm_sdu_pkg::MAX_DIM)) begin
            dim_over_next = 1'b1;
          end
          if (phase == PH_WIDTH) begin
            width_store_next = fin_value[ppm_sdu_pkg::DIM_W-1:0];
            phase_next       = PH_HEIGHT;
          end else begin
            height_store_next = fin_value[ppm_sdu_pkg::DIM_W-1:0];
            phase_next        = PH_MAXVAL;
          end
        end
      end else if (phase == PH_MAXVAL) begin
        if (fin_value != ppm_sdu_pkg::SAMPLE_MAX) begin
          res_valid = 1'b1; res = fail_res(ppm_sdu_pkg::ST_UNSUPPORTED); finished_next = 1'b1;
        end else if (!ascii_mode && (fin_term != TERM_SPACE)) begin
          res_valid = 1'b1; res = fail_res(ppm_sdu_pkg::ST_MALFORMED); finished_next = 1'b1;
        end else if (dim_over) begin
          res_valid = 1'b1; res = fail_res(ppm_sdu_pkg::ST_DIM_LIMIT); finished_next = 1'b1;
        end else begin
          phase_next         = ascii_mode ? PH_ASC : PH_BIN;
          pixels_left_next   = ppm_sdu_pkg::PIX_W'(width_store) *
                               ppm_sdu_pkg::PIX_W'(height_store);
          channel_index_next = '0;
        end
      end
    end

    if (take) begin
      unique case (channel_index)
        2'd0: begin
          red_hold_next      = sample;
          channel_index_next = 2'd1;
        end
        2'd1: begin
          green_hold_next    = sample;
          channel_index_next = 2'd2;
        end
        default: begin
          channel_index_next = 2'd0;
          left_dec           = (pixels_left != '0) ? pixels_left - 1'b1 : pixels_left;
          pixels_left_next   = left_dec;
          res_valid          = 1'b1;
          res.pixel_value    = ppm_sdu_pkg::PIXEL_ALPHA | {8'h00, red_hold, green_hold, sample};
          res.status         = ppm_sdu_pkg::ST_OK;
          res.image_done     = (left_dec == '0);
          res.image_width    = ppm_sdu_pkg::IMG_DIM_W'(width_store);
          res.image_height   = ppm_sdu_pkg::IMG_DIM_W'(height_store);
          if (left_dec == '0) begin
            finished_next = 1'b1;
          end
        end
      endcase
    end

    // A source that ends before its image is complete is an error, and the
    // decoder then starts afresh for the next source.
    if (end_of_source) begin
      if (!finished_next) begin
        res_valid = 1'b1;
        if ((phase_next == PH_BIN) || (phase_next == PH_ASC)) begin
          res = fail_res(ppm_sdu_pkg::ST_MALFORMED);
        end else begin
          res = fail_res(ppm_sdu_pkg::ST_UNSUPPORTED);
        end
      end
      phase_next         = PH_MAGIC;
      ascii_mode_next    = 1'b0;
      number_accum_next  = '0;
      token_length_next  = '0;
      in_comment_next    = 1'b0;
      token_bad_next     = 1'b0;
      dim_over_next      = 1'b0;
      width_store_next   = '0;
      height_store_next  = '0;
      channel_index_next = '0;
      red_hold_next      = '0;
      green_hold_next    = '0;
      pixels_left_next   = '0;
      finished_next      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_MAGIC;
      ascii_mode    <= 1'b0;
      number_accum  <= '0;
      token_length  <= '0;
      in_comment    <= 1'b0;
      token_bad     <= 1'b0;
      dim_over      <= 1'b0;
      width_store   <= '0;
      height_store  <= '0;
      channel_index <= '0;
      red_hold      <= '0;
      green_hold    <= '0;
      pixels_left   <= '0;
      finished      <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      ascii_mode    <= ascii_mode_next;
      number_accum  <= number_accum_next;
      token_length  <= token_length_next;
      in_comment    <= in_comment_next;
      token_bad     <= token_bad_next;
      dim_over      <= dim_over_next;
      width_store   <= width_store_next;
      height_store  <= height_store_next;
      channel_index <= channel_index_next;
      red_hold      <= red_hold_next;
      green_hold    <= green_hold_next;
      pixels_left   <= pixels_left_next;
      finished      <= finished_next;
    end
  end

  `PPM_SDU_ASSERT(a_quiet_when_finished, finished |-> !res_valid, "result after image end")
  `PPM_SDU_ASSERT_NEXT(a_restart_after_source, step && end_of_source, (phase == PH_MAGIC) && !finished, "no restart after source end")
  `PPM_SDU_ASSERT_NEXT(a_done_sets_finished, step && res_valid && res.image_done && !end_of_source, finished, "done result left decoder running")

endmodule

FILE: rtl/core/ppm_sdu_out_buf.sv
// ----------------------------------------------------------------------------
// PPM stream decoder output buffer
// Two-entry result queue: an output register backed by a skid slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ppm_stream_decoder_unit_assert.svh"

module ppm_sdu_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ppm_sdu_pkg::res_t  push_res,
  input  logic               out_stall,
  output logic               out_valid,
  output ppm_sdu_pkg::res_t  head,
  output logic               space
);

  logic [1:0]         count, count_next;
  logic               pop;
  ppm_sdu_pkg::res_t  slot0;
  ppm_sdu_pkg::res_t  slot1;

  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign space     = !count[1];
  assign head      = slot0;

  always_comb begin
    unique case ({push, pop})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  // The head beat moves on only when taken; the skid slot refills it when full, else a pushed beat does.
  always_ff @(posedge clk) begin
    unique case (count)
      2'd0: begin
        if (push) begin
          slot0 <= push_res;
        end
      end
      2'd1: begin
        if (push && pop) begin
          slot0 <= push_res;
        end else if (push) begin
          slot1 <= push_res;
        end
      end
      default: begin
        if (pop) begin
          slot0 <= slot1;
        end
      end
    endcase
  end

  `PPM_SDU_ASSERT(a_no_overflow, push |-> (count != 2'd2), "push into full buffer")
  `PPM_SDU_ASSERT(a_count_range, count != 2'd3, "buffer count out of range")
  `PPM_SDU_ASSERT_NEXT(a_skid_moves_up, (count == 2'd2) && pop, slot0 == $past(slot1), "skid beat lost")

endmodule

FILE: rtl/core/ppm_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// PPM stream decoder unit
// Decodes a P6 or P3 PPM byte stream into opaque ARGB8888 pixel beats.
// ----------------------------------------------------------------------------
// The input channel takes one source byte per beat on data_byte, with
// end_of_source high on the final byte of each source. The output channel
// gives one beat per pixel, or a single error beat with a non-zero status,
// zero pixel and dimensions, and image_done high. image_done also marks the
// last pixel of an image. Header bytes and bytes after the end of an image
// give no beat.
// A beat is taken at a rising edge where valid is high and stall is low.
// One byte is taken in every cycle while in_stall is low. A byte is decoded
// while it sits in the input register, and its result is registered in a
// two-entry output queue that holds results for the receiver.
// While the receiver stalls, header bytes still flow; once the queue is full,
// in_stall rises on the first byte that would give another result.
// Reset clears the decoder to expect a new magic token and empties the queue.
// The final byte of every source leaves the decoder ready for the next one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppm_stream_decoder_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        data_byte,
  input  logic                              end_of_source,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [31:0]                       pixel_value,
  output logic [1:0]                        status,
  output logic                              image_done,
  output logic [ppm_sdu_pkg::IMG_DIM_W-1:0] image_width,
  output logic [ppm_sdu_pkg::IMG_DIM_W-1:0] image_height
);

  logic               s1_valid;
  logic [7:0]         s1_byte;
  logic               s1_last;
  logic               in_take;
  logic               consume;
  logic               res_valid;
  ppm_sdu_pkg::res_t  res;
  ppm_sdu_pkg::res_t  head;
  logic               space;

  // The held byte is decoded when its result, if any, has room in the queue.
  assign consume  = s1_valid && (!res_valid || space);
  assign in_stall = s1_valid && !consume;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (consume) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte <= data_byte;
      s1_last <= end_of_source;
    end
  end

  ppm_sdu_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .step          (consume),
    .data_byte     (s1_byte),
    .end_of_source (s1_last),
    .res_valid     (res_valid),
    .res           (res)
  );

  ppm_sdu_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (consume && res_valid),
    .push_res  (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .head      (head),
    .space     (space)
  );

  assign pixel_value  = head.pixel_value;
  assign status       = head.status;
  assign image_done   = head.image_done;
  assign image_width  = head.image_width;
  assign image_height = head.image_height;

endmodule
